### rtl/dfd_pkg.sv
`timescale 1ns / 1ps
package dfd_pkg;

   localparam int FRAME_LEN   = 64;
   localparam int STORE_DEPTH = FRAME_LEN - 1;
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int BYTE_W      = 8;
   localparam int DROP_W      = 32;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] REG_START  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_END    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FILLER = 2'd2;

   localparam logic [BYTE_W-1:0] START_RESET  = 8'd1;
   localparam logic [BYTE_W-1:0] END_RESET    = 8'd2;
   localparam logic [BYTE_W-1:0] FILLER_RESET = 8'd0;

   typedef struct packed {
      logic accept;
      logic drain_start;
      logic rd_issue;
      logic out_load;
   } dfd_cmd_type;

   typedef struct packed {
      logic drain_req;
      logic rd_done;
      logic pend_valid;
      logic out_space;
   } dfd_status_type;

endpackage

### rtl/delimited_frame_deframer.sv
// datapath: payload bytes go from the store via the read stage to the output register
// throughput: one link word per cycle while a frame is received; an end byte with
//   stored bytes holds the input while the single store read port drains
//   the frame at one byte per cycle (longer under output stall)
// reset: synchronous, active high; delimiters return to 1/2/0, frame state and drop
//   count clear, the payload store is not cleared
`timescale 1ns / 1ps
module delimited_frame_deframer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [dfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dfd_pkg::BYTE_W-1:0]    csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dfd_pkg::BYTE_W-1:0]    req_data_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dfd_pkg::BYTE_W-1:0]    rsp_payload_byte,
   output logic                          rsp_last_of_frame,
   output logic [dfd_pkg::DROP_W-1:0]    rsp_drop_count
);

   dfd_pkg::dfd_cmd_type    cmd;
   dfd_pkg::dfd_status_type status;

   dfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dfd_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_data_byte     (req_data_byte),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_drop_count    (rsp_drop_count),
      .cmd               (cmd),
      .status            (status)
   );

   // read stage is empty whenever input words are taken
   a_pend_empty_on_accept: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !status.pend_valid)
      else $error("read stage busy while taking input");

   // a read never overruns a full read stage
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_issue |-> (!status.pend_valid || status.out_space))
      else $error("store read overruns pending word");

   // a frame in flight keeps the input closed until its last word is out
   a_frame_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_frame) |-> req_stall)
      else $error("input open mid frame");

   // a drain starts on a taken word and then holds the input
   a_drain_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.drain_start |=> req_stall)
      else $error("drain started without holding input");

endmodule

### rtl/dfd_ctrl.sv
`timescale 1ns / 1ps
module dfd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  dfd_pkg::dfd_status_type status,
   output dfd_pkg::dfd_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in        = state_ff;
      req_stall       = 1'b1;
      cmd.accept      = 1'b0;
      cmd.drain_start = 1'b0;
      cmd.rd_issue    = 1'b0;
      cmd.out_load    = status.pend_valid && status.out_space;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid && status.drain_req) begin
               cmd.drain_start = 1'b1;
               state_in        = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.rd_issue = !status.rd_done && (!status.pend_valid || status.out_space);
            if (status.rd_done && (!status.pend_valid || status.out_space)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/dfd_datapath.sv
`timescale 1ns / 1ps
module dfd_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [dfd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dfd_pkg::BYTE_W-1:0]         csr_wdata,
   input  logic [dfd_pkg::BYTE_W-1:0]         req_data_byte,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output logic [dfd_pkg::BYTE_W-1:0]         rsp_payload_byte,
   output logic                               rsp_last_of_frame,
   output logic [dfd_pkg::DROP_W-1:0]         rsp_drop_count,
   input  dfd_pkg::dfd_cmd_type               cmd,
   output dfd_pkg::dfd_status_type            status
);

   logic [dfd_pkg::BYTE_W-1:0] start_ff;
   logic [dfd_pkg::BYTE_W-1:0] end_ff;
   logic [dfd_pkg::BYTE_W-1:0] filler_ff;

   logic                       in_frame_ff, in_frame_in;
   logic [dfd_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [dfd_pkg::DROP_W-1:0] lost_ff, lost_in;
   logic                       mem_we;

   logic [dfd_pkg::BYTE_W-1:0] mem [dfd_pkg::STORE_DEPTH];

   logic [dfd_pkg::CNT_W-1:0]  drain_len_ff;
   logic [dfd_pkg::CNT_W-1:0]  rd_cnt_ff;
   logic [dfd_pkg::CNT_W-1:0]  rd_next;

   logic [dfd_pkg::BYTE_W-1:0] mem_q_ff;
   logic                       pend_valid_ff;
   logic                       pend_last_ff;
   logic [dfd_pkg::DROP_W-1:0] pend_drop_ff;

   logic                       out_valid_ff;
   logic [dfd_pkg::BYTE_W-1:0] out_byte_ff;
   logic                       out_last_ff;
   logic [dfd_pkg::DROP_W-1:0] out_drop_ff;

   logic is_start, is_end, is_filler, is_full;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= dfd_pkg::START_RESET;
         end_ff    <= dfd_pkg::END_RESET;
         filler_ff <= dfd_pkg::FILLER_RESET;
      end else if (csr_we) begin
         case (csr_index)
            dfd_pkg::REG_START:  start_ff  <= csr_wdata;
            dfd_pkg::REG_END:    end_ff    <= csr_wdata;
            dfd_pkg::REG_FILLER: filler_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // word classification
   assign is_start  = (req_data_byte == start_ff);
   assign is_end    = (req_data_byte == end_ff);
   assign is_filler = (req_data_byte == filler_ff);
   assign is_full   = (count_ff == dfd_pkg::CNT_W'(dfd_pkg::STORE_DEPTH));

   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      lost_in     = lost_ff;
      mem_we      = 1'b0;
      if (cmd.accept) begin
         if (is_start) begin
            if (in_frame_ff && (count_ff != '0)) begin
               lost_in = lost_ff + dfd_pkg::DROP_W'(1);
            end
            in_frame_in = 1'b1;
            count_in    = '0;
         end else if (!in_frame_ff) begin
            in_frame_in = 1'b0;
         end else if (is_end) begin
            in_frame_in = 1'b0;
            count_in    = '0;
         end else if (is_filler) begin
            in_frame_in = 1'b1;
         end else if (is_full) begin
            lost_in     = lost_ff + dfd_pkg::DROP_W'(1);
            in_frame_in = 1'b0;
            count_in    = '0;
         end else begin
            mem_we   = 1'b1;
            count_in = count_ff + dfd_pkg::CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         count_ff    <= '0;
         lost_ff     <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
         lost_ff     <= lost_in;
      end
   end

   // payload store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[dfd_pkg::ADDR_W-1:0]] <= req_data_byte;
      end
      if (cmd.rd_issue) begin
         mem_q_ff <= mem[rd_cnt_ff[dfd_pkg::ADDR_W-1:0]];
      end
   end

   // drain address counter
   assign rd_next = rd_cnt_ff + dfd_pkg::CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_cnt_ff    <= '0;
         drain_len_ff <= '0;
      end else if (cmd.drain_start) begin
         rd_cnt_ff    <= '0;
         drain_len_ff <= count_ff;
      end else if (cmd.rd_issue) begin
         rd_cnt_ff <= rd_next;
      end
   end

   // read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.rd_issue) begin
         pend_valid_ff <= 1'b1;
      end else if (cmd.out_load) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         pend_last_ff <= (rd_next == drain_len_ff);
         pend_drop_ff <= lost_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_byte_ff <= mem_q_ff;
         out_last_ff <= pend_last_ff;
         out_drop_ff <= pend_drop_ff;
      end
   end

   assign status.drain_req  = !is_start && in_frame_ff && is_end && (count_ff != '0);
   assign status.rd_done    = (rd_cnt_ff == drain_len_ff);
   assign status.pend_valid = pend_valid_ff;
   assign status.out_space  = !out_valid_ff || !rsp_stall;

   assign rsp_valid         = out_valid_ff;
   assign rsp_payload_byte  = out_byte_ff;
   assign rsp_last_of_frame = out_last_ff;
   assign rsp_drop_count    = out_drop_ff;

endmodule
